@@ rtl/core/frontier_cell_detector_defines.svh @@
// assertion macros used by the checker of the frontier cell detector
`ifndef FRONTIER_CELL_DETECTOR_DEFINES_SVH
`define FRONTIER_CELL_DETECTOR_DEFINES_SVH

// same-cycle implication
`define FCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/fcd_pkg.sv @@
package fcd_pkg;

   localparam int CFG_W         = 11;
   localparam int ROW_W         = 10;
   localparam int COL_W         = 10;
   localparam int OCC_W         = 8;
   localparam int CSR_IDX_W     = 2;
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT    = 1024;
   localparam int LINE_W        = 4;

   localparam logic [CFG_W-1:0] RESET_DIM = CFG_W'(3);

   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      CODE_OUT     = 2'd0,
      CODE_FREE    = 2'd1,
      CODE_UNKNOWN = 2'd2,
      CODE_OTHER   = 2'd3
   } code_type;

endpackage

@@ rtl/core/fcd_ram.sv @@
module fcd_ram #(
   parameter int WIDTH = fcd_pkg::LINE_W,
   parameter int DEPTH = fcd_pkg::DEF_MAX_WIDTH
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/frontier_cell_detector.sv @@
// Frontier cell detector for an occupancy grid streamed in raster order.
// Input channel (req_*): one cell per item, req_cmd 0 for a grid cell and 1 for a
// pad item; after the width*height cells of a frame, width+1 pad items flush out
// the remaining classifications. Every input item gives exactly one result item.
// Result channel (rsp_*): rsp_valid_res marks a classified cell with its row and
// column; the classified cell trails the input by width+1 items. rsp_last marks
// the final cell, after which the next item starts a new frame.
// Configuration (csr_*): grid width and height, always ready; a write restarts
// the frame. Write only while no item is in flight.
// An accepted item is held in the stage 1 registers and moves on to the output
// register when that register is free or being read. Throughput is one item per cycle
// while the receiver does not stall; the line memory does one read and one write per
// cycle, and a read of the entry written in the same cycle is forwarded.
// Reset clears the counters, the 3x3 window and the pipeline valid bits; the line
// memory is not cleared, as its entries for rows above the grid are never used.
// When the receiver stalls, the result holds and req_stall rises once the
// internal stage behind the output register is full.
module frontier_cell_detector #(
   parameter int MAX_WIDTH = fcd_pkg::DEF_MAX_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic signed [fcd_pkg::OCC_W-1:0] req_occupancy,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_valid_res,
   output logic                           rsp_is_frontier,
   output logic [fcd_pkg::ROW_W-1:0]      rsp_row,
   output logic [fcd_pkg::COL_W-1:0]      rsp_col,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fcd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fcd_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int CFG_W  = fcd_pkg::CFG_W;
   localparam int ROW_W  = fcd_pkg::ROW_W;
   localparam int COL_W  = fcd_pkg::COL_W;
   localparam int LINE_W = fcd_pkg::LINE_W;

   function automatic fcd_pkg::code_type map_code(input logic signed [fcd_pkg::OCC_W-1:0] v);
      fcd_pkg::code_type c;
      if (v > 1 || v == -1) begin
         c = fcd_pkg::CODE_UNKNOWN;
      end else if (v == 0) begin
         c = fcd_pkg::CODE_FREE;
      end else begin
         c = fcd_pkg::CODE_OTHER;
      end
      return c;
   endfunction

   // configuration
   logic [CFG_W-1:0] grid_width_ff, grid_width_in;
   logic [CFG_W-1:0] grid_height_ff, grid_height_in;
   logic             csr_hit;
   logic [CFG_W-1:0] eff_w, eff_h;

   // input position
   logic [ADDR_W-1:0] in_col_ff, in_col_in;
   logic [CFG_W-1:0]  in_row_ff, in_row_in;

   // stage 0
   logic              accept;
   logic              col_zero;
   logic [CFG_W-1:0]  in_col_w;
   logic [CFG_W-1:0]  ccol, crow;
   logic              cell_ok, is_last;
   fcd_pkg::code_type newc;

   // stage 1
   logic              s1_vld_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   fcd_pkg::code_type s1_newc_ff;
   logic              s1_use_top_ff, s1_use_mid_ff;
   logic              s1_res_ff, s1_first_ff, s1_lastcol_ff, s1_last_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              s1_go;

   // line memory and forwarding
   logic [LINE_W-1:0] ram_rdata, line_rd, ram_wdata;
   logic              fwd_vld_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [LINE_W-1:0] fwd_data_ff;
   fcd_pkg::code_type top, mid;

   // window
   fcd_pkg::code_type win_ff [3][3];
   fcd_pkg::code_type win_in [3][3];
   logic              frontier;

   // output register
   logic              rsp_valid_ff;
   logic              rsp_res_ff, rsp_front_ff, rsp_last_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;

   assign csr_ready = 1'b1;
   assign csr_hit   = csr_valid && csr_ready &&
                      (csr_index == fcd_pkg::REG_GRID_WIDTH ||
                       csr_index == fcd_pkg::REG_GRID_HEIGHT);

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_valid && csr_ready && csr_index == fcd_pkg::REG_GRID_WIDTH) begin
         grid_width_in = csr_wdata;
      end
      if (csr_valid && csr_ready && csr_index == fcd_pkg::REG_GRID_HEIGHT) begin
         grid_height_in = csr_wdata;
      end
   end

   always_comb begin
      if (grid_width_ff == '0) begin
         eff_w = CFG_W'(1);
      end else if (32'(grid_width_ff) > MAX_WIDTH) begin
         eff_w = CFG_W'(MAX_WIDTH);
      end else begin
         eff_w = grid_width_ff;
      end
      if (grid_height_ff == '0) begin
         eff_h = CFG_W'(1);
      end else if (32'(grid_height_ff) > fcd_pkg::MAX_HEIGHT) begin
         eff_h = CFG_W'(fcd_pkg::MAX_HEIGHT);
      end else begin
         eff_h = grid_height_ff;
      end
   end

   // stage 0: position of the window centre and code of the new cell
   assign accept   = req_valid && !req_stall;
   assign col_zero = (in_col_ff == '0);
   assign in_col_w = CFG_W'(in_col_ff);

   always_comb begin
      if (col_zero) begin
         ccol    = eff_w - CFG_W'(1);
         crow    = in_row_ff - CFG_W'(2);
         cell_ok = (in_row_ff >= CFG_W'(2)) && (crow < eff_h);
      end else begin
         ccol    = in_col_w - CFG_W'(1);
         crow    = in_row_ff - CFG_W'(1);
         cell_ok = (in_row_ff >= CFG_W'(1)) && (crow < eff_h);
      end
      is_last = cell_ok && (crow == eff_h - CFG_W'(1)) && (ccol == eff_w - CFG_W'(1));
      if (!req_cmd && in_row_ff < eff_h) begin
         newc = map_code(req_occupancy);
      end else begin
         newc = fcd_pkg::CODE_OUT;
      end
   end

   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (csr_hit) begin
         in_col_in = '0;
         in_row_in = '0;
      end else if (accept) begin
         if (is_last) begin
            in_col_in = '0;
            in_row_in = '0;
         end else if ((in_col_w + CFG_W'(1)) >= eff_w) begin
            in_col_in = '0;
            in_row_in = in_row_ff + CFG_W'(1);
         end else begin
            in_col_in = in_col_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= fcd_pkg::RESET_DIM;
         grid_height_ff <= fcd_pkg::RESET_DIM;
         in_col_ff      <= '0;
         in_row_ff      <= '0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         in_col_ff      <= in_col_in;
         in_row_ff      <= in_row_in;
      end
   end

   fcd_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (s1_go),
      .waddr (s1_addr_ff),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (in_col_ff),
      .rdata (ram_rdata)
   );

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (accept) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_go) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff    <= in_col_ff;
         s1_newc_ff    <= newc;
         s1_use_top_ff <= (in_row_ff >= CFG_W'(2));
         s1_use_mid_ff <= (in_row_ff >= CFG_W'(1));
         s1_res_ff     <= cell_ok;
         s1_first_ff   <= (ccol == '0);
         s1_lastcol_ff <= (ccol == eff_w - CFG_W'(1));
         s1_last_ff    <= is_last;
         s1_row_ff     <= cell_ok ? crow[ROW_W-1:0] : '0;
         s1_col_ff     <= cell_ok ? ccol[COL_W-1:0] : '0;
      end
   end

   assign s1_go     = s1_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !s1_go;

   // stage 1: line update, window shift, classification
   always_comb begin
      if (fwd_vld_ff && fwd_addr_ff == s1_addr_ff) begin
         line_rd = fwd_data_ff;
      end else begin
         line_rd = ram_rdata;
      end
      top       = s1_use_top_ff ? fcd_pkg::code_type'(line_rd[3:2]) : fcd_pkg::CODE_OUT;
      mid       = s1_use_mid_ff ? fcd_pkg::code_type'(line_rd[1:0]) : fcd_pkg::CODE_OUT;
      ram_wdata = {mid, s1_newc_ff};
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = top;
      win_in[1][2] = mid;
      win_in[2][2] = s1_newc_ff;
      frontier = 1'b0;
      for (int r = 0; r < 3; r++) begin
         if (win_in[r][0] == fcd_pkg::CODE_FREE && !s1_first_ff) begin
            frontier = 1'b1;
         end
         if (win_in[r][2] == fcd_pkg::CODE_FREE && !s1_lastcol_ff) begin
            frontier = 1'b1;
         end
      end
      if (win_in[0][1] == fcd_pkg::CODE_FREE || win_in[2][1] == fcd_pkg::CODE_FREE) begin
         frontier = 1'b1;
      end
      frontier = frontier && s1_res_ff && (win_in[1][1] == fcd_pkg::CODE_UNKNOWN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_vld_ff <= 1'b0;
      end else if (s1_go) begin
         fwd_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= ram_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_hit || (s1_go && s1_last_ff)) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= fcd_pkg::CODE_OUT;
            end
         end
      end else if (s1_go) begin
         win_ff <= win_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_res_ff   <= s1_res_ff;
         rsp_front_ff <= frontier;
         rsp_last_ff  <= s1_last_ff;
         rsp_row_ff   <= s1_row_ff;
         rsp_col_ff   <= s1_col_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_valid_res   = rsp_res_ff;
   assign rsp_is_frontier = rsp_front_ff;
   assign rsp_row         = rsp_row_ff;
   assign rsp_col         = rsp_col_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

@@ rtl/core/fcd_checker.sv @@
`include "frontier_cell_detector_defines.svh"

module fcd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_valid_res,
   input logic                              rsp_is_frontier,
   input logic [fcd_pkg::ROW_W-1:0]         rsp_row,
   input logic [fcd_pkg::COL_W-1:0]         rsp_col,
   input logic                              rsp_last
);

   logic rsp_busy;
   logic no_cell;

   assign rsp_busy = rsp_valid && rsp_stall;
   assign no_cell  = rsp_valid && !rsp_valid_res;

   `FCD_ASSERT_NOW(a_idle_fields_zero, clock, reset, no_cell,
      !rsp_is_frontier && rsp_row == '0 && rsp_col == '0 && !rsp_last,
      "result without a classified cell carries nonzero fields")

   `FCD_ASSERT_NOW(a_last_is_cell, clock, reset, rsp_valid && rsp_last,
      rsp_valid_res, "last flag on a result without a classified cell")

   `FCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_busy,
      rsp_valid && $stable(rsp_is_frontier) && $stable(rsp_row) && $stable(rsp_col),
      "stalled result changed")

endmodule

bind frontier_cell_detector fcd_checker u_fcd_checker (.*);
